@@ rtl/vsp_pkg.sv @@
// Shared constants, types and helper functions of the vertex projection core.
package vsp_pkg;

    localparam int unsigned NSTG      = 21;
    localparam int unsigned DIV_BITS  = 16;
    localparam int unsigned DIV_FIRST = 4;
    localparam int unsigned DB_W      = $clog2(DIV_BITS);
    localparam int unsigned REM_W     = 48;
    localparam int unsigned DV_W      = 25;

    localparam logic [2:0] MODE_PERSP = 3'd0;
    localparam logic [2:0] MODE_ORTHO = 3'd1;
    localparam logic [2:0] MODE_ISO   = 3'd2;
    localparam logic [2:0] MODE_OBLQ  = 3'd3;
    localparam logic [2:0] MODE_AXO   = 3'd4;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_ZOOM   = 2'd1;
    localparam logic [1:0] REG_WIDTH  = 2'd2;
    localparam logic [1:0] REG_HEIGHT = 2'd3;

    localparam logic [16:0]        COS30       = 17'd56756;
    localparam logic signed [25:0] PERSP_DEPTH = 26'sd5120;

    typedef struct packed {
        logic               persp;
        logic               dz;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic               fault;
    } side_t;

    typedef struct packed {
        logic [REM_W-1:0]    rem_x;
        logic [REM_W-1:0]    rem_y;
        logic [DV_W-1:0]     dv;
        logic [DIV_BITS-1:0] q_x;
        logic [DIV_BITS-1:0] q_y;
        logic                ovf_x;
        logic                ovf_y;
        logic                neg_x;
        logic                neg_y;
        side_t               side;
    } div_t;

    // Signed division by 2^k, truncating toward zero.
    function automatic logic signed [63:0] trunc_pow2(input logic signed [63:0] v,
                                                      input logic [5:0] k);
        logic signed [63:0] bias;
        bias = v[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
        return (v + bias) >>> k;
    endfunction

    // Clamp to signed 16 bits; the top bit flags a clamp.
    function automatic logic [16:0] sat16(input logic signed [63:0] r);
        logic [16:0] res;
        if (r > 64'sd32767)
            res = {1'b1, 16'h7FFF};
        else if (r < -64'sd32768)
            res = {1'b1, 16'h8000};
        else
            res = {1'b0, r[15:0]};
        return res;
    endfunction

    // Apply the sign to a divider quotient and clamp; the top bit flags a clamp.
    function automatic logic [16:0] quot_sat(input logic [DIV_BITS-1:0] q,
                                             input logic ovf, input logic neg);
        logic [16:0] res;
        if (ovf || (!neg && q[DIV_BITS-1]) || (neg && q > 16'd32768))
            res = {1'b1, (neg ? 16'h8000 : 16'h7FFF)};
        else
            res = {1'b0, (neg ? 16'(~q + 16'd1) : q)};
        return res;
    endfunction

endpackage

@@ rtl/vsp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, for both screen axes.
module vsp_div
    import vsp_pkg::*;
(
    input  logic                clk,
    input  logic [DIV_BITS-1:0] ld,
    input  div_t                din,
    output div_t                dout
);

    div_t st_reg [DIV_BITS];

    function automatic div_t div_step(input div_t a, input logic [DB_W-1:0] b);
        div_t             r;
        logic [REM_W-1:0] sh;
        r  = a;
        sh = REM_W'(a.dv) << b;
        if (a.rem_x >= sh)
        begin
            r.rem_x  = a.rem_x - sh;
            r.q_x[b] = 1'b1;
        end
        if (a.rem_y >= sh)
        begin
            r.rem_y  = a.rem_y - sh;
            r.q_y[b] = 1'b1;
        end
        return r;
    endfunction

    genvar j;
    generate
        for (j = 0; j < DIV_BITS; j++)
        begin : g_stage
            localparam logic [DB_W-1:0] BIT = DB_W'(DIV_BITS - 1 - j);
            if (j == 0)
            begin : g_first
                always_ff @(posedge clk)
                begin
                    if (ld[j])
                        st_reg[j] <= div_step(din, BIT);
                end
            end
            else
            begin : g_rest
                always_ff @(posedge clk)
                begin
                    if (ld[j])
                        st_reg[j] <= div_step(st_reg[j-1], BIT);
                end
            end
        end
    endgenerate

    assign dout = st_reg[DIV_BITS-1];

endmodule

@@ rtl/vertex_screen_projection_core.sv @@
// Top level of the vertex screen projection core.
// Projects one Q16.8 vertex per transaction onto the screen in the mode held in the
// mode register, and accepts a new vertex every cycle unless back-pressure stalls the
// first stage. Every vertex passes 21 register stages, whatever the mode: two multiply
// stages, a numerator stage, a setup stage, the 16-stage restoring divider of the
// perspective path and the output register. Each stage holds its vertex only while
// the stage after it is full and stalled, so gaps close up under back-pressure. Write
// the registers only while no vertex is in flight.
module vertex_screen_projection_core
    import vsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // vert_x[23:0], vert_y[47:24], vert_z[71:48]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // screen_x[15:0], screen_y[31:16], range_fault[32]
);

    logic [2:0]  mode_reg;
    logic [15:0] zoom_reg;
    logic [11:0] sw_reg;
    logic [11:0] sh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_PERSP;
            zoom_reg <= 16'd256;
            sw_reg   <= 12'd640;
            sh_reg   <= 12'd480;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_MODE:   mode_reg <= cfg_data[2:0];
                REG_ZOOM:   zoom_reg <= cfg_data;
                REG_WIDTH:  sw_reg   <= cfg_data[11:0];
                REG_HEIGHT: sh_reg   <= cfg_data[11:0];
                default:    mode_reg <= mode_reg;
            endcase
        end
    end

    logic signed [16:0] zs;
    logic signed [11:0] hxs;
    logic signed [11:0] hys;
    assign zs  = $signed({1'b0, zoom_reg});
    assign hxs = $signed({1'b0, sw_reg[11:1]});
    assign hys = $signed({1'b0, sh_reg[11:1]});

    // Stage valid bits and load enables
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] free;

    always_comb
    begin
        free[NSTG-1] = !v_reg[NSTG-1] || m_tready;
        for (int i = NSTG - 2; i >= 0; i--)
            free[i] = !v_reg[i] || free[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (free[0])
                v_reg[0] <= s_tvalid;
            for (int i = 1; i < NSTG; i++)
                if (free[i])
                    v_reg[i] <= v_reg[i-1];
        end
    end

    assign s_tready = free[0];

    // Stage 0: first multiplies
    logic signed [25:0] xe, ye, ze;
    logic signed [25:0] ma, mb;
    logic [16:0]        ka, kb;
    logic signed [43:0] pa_reg, pb_reg, pz_reg;
    logic signed [25:0] x1_reg, y1_reg, z1_reg;

    assign xe = 26'(signed'(s_tdata[23:0]));
    assign ye = 26'(signed'(s_tdata[47:24]));
    assign ze = 26'(signed'(s_tdata[71:48]));

    always_comb
    begin
        ma = '0;
        mb = '0;
        ka = '0;
        kb = '0;
        unique case (mode_reg) inside
            MODE_PERSP, MODE_ORTHO:
            begin
                ma = xe;
                mb = ye;
                ka = {1'b0, zoom_reg};
                kb = {1'b0, zoom_reg};
            end
            MODE_ISO:
            begin
                ma = xe - ye;
                mb = xe + ye;
                ka = COS30;
                kb = {1'b0, zoom_reg};
            end
            MODE_OBLQ:
            begin
                ma = (xe <<< 1) + ze;
                mb = (ye <<< 1) + ze;
                ka = {1'b0, zoom_reg};
                kb = {1'b0, zoom_reg};
            end
            MODE_AXO:
            begin
                ma = xe;
                mb = ye;
                ka = COS30;
                kb = COS30;
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (free[0])
        begin
            pa_reg <= 44'(ma) * 44'($signed({1'b0, ka}));
            pb_reg <= 44'(mb) * 44'($signed({1'b0, kb}));
            pz_reg <= 44'(ze) * 44'(zs);
            x1_reg <= xe;
            y1_reg <= ye;
            z1_reg <= ze;
        end
    end

    // Stage 1: perspective scale by 20, axonometric shear term, half-screen times depth
    logic signed [25:0] d1;
    logic signed [45:0] ta_next, tb_next;
    logic signed [45:0] ta_reg, tb_reg;
    logic signed [37:0] hxd_reg, hyd_reg;
    logic signed [43:0] pz2_reg;
    logic signed [25:0] x2_reg, d2_reg;

    assign d1 = PERSP_DEPTH - z1_reg;

    always_comb
    begin
        ta_next = 46'(pa_reg);
        tb_next = 46'(pb_reg);
        if (mode_reg == MODE_PERSP)
        begin
            ta_next = (46'(pa_reg) <<< 4) + (46'(pa_reg) <<< 2);
            tb_next = (46'(pb_reg) <<< 4) + (46'(pb_reg) <<< 2);
        end
        else if (mode_reg == MODE_AXO)
            ta_next = 46'(pa_reg) - (46'(y1_reg) <<< 15);
    end

    always_ff @(posedge clk)
    begin
        if (free[1])
        begin
            ta_reg  <= ta_next;
            tb_reg  <= tb_next;
            hxd_reg <= 38'(d1) * 38'(hxs);
            hyd_reg <= 38'(d1) * 38'(hys);
            pz2_reg <= pz_reg;
            x2_reg  <= x1_reg;
            d2_reg  <= d1;
        end
    end

    // Stage 2: second multiply and full numerators
    logic signed [63:0] prod;
    logic signed [63:0] nx, ny;
    logic signed [63:0] nx_reg, ny_reg;
    logic signed [25:0] d3_reg;

    assign prod = 64'(ta_reg) * 64'(zs);

    always_comb
    begin
        nx = '0;
        ny = '0;
        unique case (mode_reg) inside
            MODE_PERSP:
            begin
                nx = 64'(ta_reg) + (64'(hxd_reg) <<< 8);
                ny = 64'(tb_reg) + (64'(hyd_reg) <<< 8);
            end
            MODE_ORTHO:
            begin
                nx = 64'(ta_reg) + (64'(hxs) <<< 16);
                ny = 64'(tb_reg) + (64'(hys) <<< 16);
            end
            MODE_ISO:
            begin
                nx = prod + (64'(hxs) <<< 32);
                ny = (64'(tb_reg) <<< 15) - (64'(pz2_reg) <<< 16) + (64'(hys) <<< 32);
            end
            MODE_OBLQ:
            begin
                nx = 64'(ta_reg) + (64'(hxs) <<< 17);
                ny = 64'(tb_reg) + (64'(hys) <<< 17);
            end
            MODE_AXO:
            begin
                nx = prod + (64'(hxs) <<< 32);
                ny = (64'(x2_reg) <<< 15) + 64'(tb_reg) - (64'(pz2_reg) <<< 8)
                     + (64'(hys) <<< 24);
            end
            default:
            begin
                nx = '0;
                ny = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (free[2])
        begin
            nx_reg <= nx;
            ny_reg <= ny;
            d3_reg <= d2_reg;
        end
    end

    // Stage 3: power-of-two modes finish here, perspective sets up the divider
    logic [63:0]  absx, absy;
    logic [25:0]  absd;
    logic [5:0]   kx, ky;
    logic [16:0]  satx, saty;
    logic         ortho_like;
    div_t         div_in;
    div_t         div_reg;
    div_t         dout;

    assign absx = nx_reg[63] ? 64'(-nx_reg) : 64'(nx_reg);
    assign absy = ny_reg[63] ? 64'(-ny_reg) : 64'(ny_reg);
    assign absd = d3_reg[25] ? 26'(-d3_reg) : 26'(d3_reg);

    always_comb
    begin
        kx         = 6'd16;
        ky         = 6'd16;
        ortho_like = 1'b1;
        unique case (mode_reg) inside
            MODE_ORTHO:
            begin
                kx = 6'd16;
                ky = 6'd16;
            end
            MODE_ISO:
            begin
                kx = 6'd32;
                ky = 6'd32;
            end
            MODE_OBLQ:
            begin
                kx = 6'd17;
                ky = 6'd17;
            end
            MODE_AXO:
            begin
                kx = 6'd32;
                ky = 6'd24;
            end
            default:
                ortho_like = 1'b0;
        endcase
    end

    assign satx = sat16(trunc_pow2(nx_reg, kx));
    assign saty = sat16(trunc_pow2(ny_reg, ky));

    always_comb
    begin
        div_in            = '0;
        div_in.rem_x      = absx[REM_W+7:8];
        div_in.rem_y      = absy[REM_W+7:8];
        div_in.dv         = absd[DV_W-1:0];
        div_in.ovf_x      = div_in.rem_x >= (REM_W'(div_in.dv) << DIV_BITS);
        div_in.ovf_y      = div_in.rem_y >= (REM_W'(div_in.dv) << DIV_BITS);
        div_in.neg_x      = nx_reg[63] ^ d3_reg[25];
        div_in.neg_y      = ny_reg[63] ^ d3_reg[25];
        div_in.side.persp = (mode_reg == MODE_PERSP);
        div_in.side.dz    = (d3_reg == '0);
        if (ortho_like)
        begin
            div_in.side.rx    = satx[15:0];
            div_in.side.ry    = saty[15:0];
            div_in.side.fault = satx[16] | saty[16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (free[3])
            div_reg <= div_in;
    end

    vsp_div u_div (
        .clk  (clk),
        .ld   (free[DIV_FIRST+DIV_BITS-1:DIV_FIRST]),
        .din  (div_reg),
        .dout (dout)
    );

    // Output stage
    logic [16:0] qx, qy;
    logic [39:0] out_next;
    logic [39:0] out_reg;

    assign qx = quot_sat(dout.q_x, dout.ovf_x, dout.neg_x);
    assign qy = quot_sat(dout.q_y, dout.ovf_y, dout.neg_y);

    always_comb
    begin
        if (!dout.side.persp)
            out_next = {7'd0, dout.side.fault, dout.side.ry, dout.side.rx};
        else if (dout.side.dz)
            out_next = {7'd0, 1'b1, 16'd0, 16'd0};
        else
            out_next = {7'd0, qx[16] | qy[16], qy[15:0], qx[15:0]};
    end

    always_ff @(posedge clk)
    begin
        if (free[NSTG-1])
            out_reg <= out_next;
    end

    assign m_tvalid = v_reg[NSTG-1];
    assign m_tdata  = out_reg;

    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while the output stage can move");

    a_take_to_stage0: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> v_reg[0])
        else $error("accepted transaction did not enter the first stage");

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[NSTG-2] && dout.side.persp && !dout.side.dz && !dout.ovf_x)
        |-> (dout.rem_x < REM_W'(dout.dv)))
        else $error("divider remainder not below divisor");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !v_reg[NSTG-2]) |=> !m_tvalid)
        else $error("output stage holds a transaction that was taken");

endmodule

@@ test/vertex_screen_projection_core_tb.sv @@
// Self-checking testbench of the vertex screen projection core.
`timescale 1ns / 100ps

class projection_scoreboard;
    logic [2:0]  mode;
    logic [15:0] zoom;
    logic [11:0] width;
    logic [11:0] height;
    logic [32:0] pending_q[$];
    int          errors;

    function void set_reg(logic [1:0] addr, logic [15:0] data);
        case (addr)
            vsp_pkg::REG_MODE:   mode = data[2:0];
            vsp_pkg::REG_ZOOM:   zoom = data;
            vsp_pkg::REG_WIDTH:  width = data[11:0];
            vsp_pkg::REG_HEIGHT: height = data[11:0];
            default: ;
        endcase
    endfunction

    // Clamp to signed 16 bits; flag any clamp.
    function logic [15:0] clamp(longint v, ref logic fault);
        if (v > 32767)
        begin
            fault = 1'b1;
            return 16'h7FFF;
        end
        if (v < -32768)
        begin
            fault = 1'b1;
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    function void note_vertex(logic [71:0] vtx);
        longint      x, y, z, s, hx, hy, rx, ry, d, den;
        logic        fault;
        logic        ok;
        logic [15:0] cx, cy;
        x = longint'($signed(vtx[23:0]));
        y = longint'($signed(vtx[47:24]));
        z = longint'($signed(vtx[71:48]));
        s = zoom;
        hx = width >> 1;
        hy = height >> 1;
        rx = 0;
        ry = 0;
        fault = 1'b0;
        ok = 1'b1;
        case (mode)
            vsp_pkg::MODE_PERSP:
            begin
                d = 5120 - z;
                if (d == 0)
                begin
                    fault = 1'b1;
                    ok = 1'b0;
                end
                else
                begin
                    den = d * 256;
                    rx = (x * 20 * s + hx * den) / den;
                    ry = (y * 20 * s + hy * den) / den;
                end
            end
            vsp_pkg::MODE_ORTHO:
            begin
                rx = (x * s + hx * 65536) / 65536;
                ry = (y * s + hy * 65536) / 65536;
            end
            vsp_pkg::MODE_ISO:
            begin
                rx = ((x - y) * 56756 * s + hx * 64'sh1_0000_0000) / 64'sh1_0000_0000;
                ry = ((x + y) * 32768 * s - z * s * 65536 + hy * 64'sh1_0000_0000)
                     / 64'sh1_0000_0000;
            end
            vsp_pkg::MODE_OBLQ:
            begin
                rx = ((2 * x + z) * s + hx * 131072) / 131072;
                ry = ((2 * y + z) * s + hy * 131072) / 131072;
            end
            vsp_pkg::MODE_AXO:
            begin
                rx = ((x * 56756 - y * 32768) * s + hx * 64'sh1_0000_0000)
                     / 64'sh1_0000_0000;
                ry = (x * 32768 + y * 56756 - z * s * 256 + hy * 16777216) / 16777216;
            end
            default: ok = 1'b0;
        endcase
        if (ok)
        begin
            cx = clamp(rx, fault);
            cy = clamp(ry, fault);
            pending_q.push_back({fault, cy, cx});
        end
        else
            pending_q.push_back({fault, 32'h0});
    endfunction

    function void check_point(logic [39:0] got);
        logic [32:0] want;
        if (pending_q.size() == 0)
        begin
            $display("%0t: unexpected point x=%h y=%h fault=%b", $time,
                     got[15:0], got[31:16], got[32]);
            errors++;
            return;
        end
        want = pending_q.pop_front();
        if (got[15:0] !== want[15:0])
        begin
            $display("%0t: screen_x expected %h actual %h", $time, want[15:0], got[15:0]);
            errors++;
        end
        if (got[31:16] !== want[31:16])
        begin
            $display("%0t: screen_y expected %h actual %h", $time, want[31:16], got[31:16]);
            errors++;
        end
        if (got[32] !== want[32])
        begin
            $display("%0t: range_fault expected %b actual %b", $time, want[32], got[32]);
            errors++;
        end
    endfunction
endclass

module vertex_screen_projection_core_tb
    import vsp_pkg::*;
();

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    projection_scoreboard board;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_off;

    vertex_screen_projection_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Receiver: random stalls, or a long hold-off when requested.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_point(m_tdata);
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic write_reg(logic [1:0] addr, logic [15:0] data);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_reg(addr, data);
    endtask

    task automatic send_vertex(logic [23:0] x, logic [23:0] y, logic [23:0] z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_vertex({z, y, x});
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (board.pending_q.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(3))
            0: return 24'($urandom);
            1: return 24'($signed(16'($urandom)));
            2: return 24'($signed(12'($urandom)));
            default: return 24'($signed(20'($urandom)));
        endcase
    endfunction

    task automatic random_phase(int count);
        logic [23:0] z;
        for (int i = 0; i < count; i++)
        begin
            z = ($urandom_range(31) == 0) ? 24'd5120 : rand_coord();
            send_vertex(rand_coord(), rand_coord(), z);
        end
    endtask

    task automatic random_regs();
        logic [15:0] zm;
        case ($urandom_range(3))
            0: zm = 16'($urandom);
            1: zm = 16'($urandom_range(512));
            2: zm = 16'hFFFF;
            default: zm = 16'd0;
        endcase
        write_reg(REG_MODE, 16'($urandom_range(7)));
        write_reg(REG_ZOOM, zm);
        write_reg(REG_WIDTH, 16'($urandom_range(4095)));
        write_reg(REG_HEIGHT, 16'($urandom_range(4095)));
    endtask

    initial
    begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        board = new();
        board.mode = MODE_PERSP;
        board.zoom = 16'd256;
        board.width = 12'd640;
        board.height = 12'd480;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = REG_MODE;
        cfg_data = 16'd0;
        s_tvalid = 1'b0;
        s_tdata = 72'd0;
        m_tready = 1'b0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every mode with extremes, far plane and reset settings.
        for (int m = 0; m < 8; m++)
        begin
            write_reg(REG_MODE, 16'(m));
            send_vertex(24'h7FFFFF, 24'h800000, 24'd5120);
            send_vertex(24'h000100, 24'hFFFF00, 24'h000000);
            send_vertex(24'h800000, 24'h7FFFFF, 24'h7FFFFF);
            drain();
        end
        drain();
        write_reg(REG_ZOOM, 16'hFFFF);
        write_reg(REG_WIDTH, 16'd0);
        write_reg(REG_HEIGHT, 16'hFFF);
        write_reg(REG_MODE, 16'(MODE_PERSP));
        send_vertex(24'h000500, 24'hFFFB00, 24'd5119);
        send_vertex(24'h000001, 24'hFFFFFF, 24'd5121);
        drain();
        write_reg(REG_ZOOM, 16'd0);
        write_reg(REG_WIDTH, 16'd1);
        write_reg(REG_HEIGHT, 16'hFFF);
        send_vertex(24'h123456, 24'hABCDEF, 24'h000000);
        drain();

        // Long receiver hold-off while input keeps coming.
        write_reg(REG_MODE, 16'(MODE_ORTHO));
        hold_off = 200;
        random_phase(60);
        drain();

        for (int ph = 0; ph < 12; ph++)
        begin
            random_regs();
            if (ph < 4)
            begin
                send_idle_pct = 11;
                recv_idle_pct = 83;
            end
            else if (ph < 8)
            begin
                send_idle_pct = 83;
                recv_idle_pct = 11;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_phase(80);
            drain();
        end

        if (board.errors == 0 && board.pending_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
